// File: rtl/bdr_pkg.sv
// Shared types, constants and register codes of the barrel distortion remapper.
package bdr_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_WIDTH_DEF  = 512;
  localparam int unsigned MAX_HEIGHT_DEF = 512;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  // Widest fractional weight the item record has to carry.
  localparam int unsigned FRAC_MAX       = 16;

  // Field and register widths.
  localparam int unsigned POS_W       = 9;
  localparam int unsigned DIM_W       = 10;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned RGB_W       = 24;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;

  // Internal arithmetic widths.
  localparam int unsigned OFS_W     = 11;  // half-pixel offset, signed
  localparam int unsigned SQ_W      = 20;  // square of one offset
  localparam int unsigned SUM_W     = 21;  // sum of both squares
  localparam int unsigned ROOT_W    = 27;  // isqrt(sum * 2^32)
  localparam int unsigned REM_W     = 31;  // square root remainder
  localparam int unsigned ZERO_PAIRS = 16; // bit pairs of the 2^32 factor
  localparam int unsigned DIV_W     = 28;  // shifted divisor
  localparam int unsigned RAD_W     = 18;  // radius, Q2.16
  localparam int unsigned D_W       = 18;  // constant term of the polynomial
  localparam int unsigned SCALE_W   = 25;  // scale factor, Q14
  localparam int unsigned CTR_SHIFT = 14;
  localparam int unsigned SRC_SHIFT = 15;
  localparam int unsigned PROD_W    = 36;  // offset times scale
  localparam int unsigned NX_W      = 37;  // centre plus offset times scale
  localparam int unsigned XC_W      = 13;  // coordinate widened for banking

  localparam logic [RAD_W-1:0] RAD_MAX = '1;
  localparam logic signed [D_W-1:0] Q14_ONE = 18'sd16384;

  // Reset values of the registers.
  localparam logic [DIM_W-1:0]         WIDTH_RST   = 10'd512;
  localparam logic [DIM_W-1:0]         HEIGHT_RST  = 10'd512;
  localparam logic signed [COEF_W-1:0] QUARTIC_RST = 16'sd1360;
  localparam logic signed [COEF_W-1:0] CUBIC_RST   = 16'sd7045;
  localparam logic signed [COEF_W-1:0] SQUARE_RST  = -16'sd3768;
  localparam logic [CH_W-1:0]          MIN_RST     = 8'd255;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_QUARTIC = 3'd2,
    REG_COEF_CUBIC   = 3'd3,
    REG_COEF_SQUARE  = 3'd4
  } cfg_reg_t;

  // Geometry and coefficients derived from the registers.
  typedef struct packed {
    logic [DIM_W-1:0]         w;
    logic [DIM_W-1:0]         h;
    logic [DIM_W-1:0]         wm1;
    logic [DIM_W-1:0]         hm1;
    logic [DIM_W-1:0]         n2;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [D_W-1:0]    d;
  } geom_t;

  // Record of one item as it travels down the pipeline.
  typedef struct packed {
    logic                     kind;
    logic [POS_W-1:0]         x;
    logic [POS_W-1:0]         y;
    logic [RGB_W-1:0]         rgb;
    logic                     in_frame;
    logic signed [OFS_W-1:0]  dx2;
    logic signed [OFS_W-1:0]  dy2;
    logic [SQ_W-1:0]          sqx;
    logic [SQ_W-1:0]          sqy;
    logic [SUM_W-1:0]         sum;
    logic [RAD_W-1:0]         r;
    logic signed [SCALE_W-1:0] s;
    logic [DIM_W-1:0]         xb;
    logic [DIM_W-1:0]         yb;
    logic [FRAC_MAX-1:0]      fx;
    logic [FRAC_MAX-1:0]      fy;
    logic [CH_W-1:0]          minv;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            sampled;
  } res_t;

endpackage

// File: rtl/bdr_if.sv
// Valid/ready channel interfaces for request items and result items.
interface bdr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [bdr_pkg::POS_W-1:0]  pos_x;
  logic [bdr_pkg::POS_W-1:0]  pos_y;
  logic [bdr_pkg::CH_W-1:0]   in_red;
  logic [bdr_pkg::CH_W-1:0]   in_green;
  logic [bdr_pkg::CH_W-1:0]   in_blue;

  modport source (output valid, kind, pos_x, pos_y, in_red, in_green, in_blue,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, in_red, in_green, in_blue,
                output ready);
endinterface

interface bdr_out_if;
  logic                      valid;
  logic                      ready;
  logic [bdr_pkg::CH_W-1:0]  out_red;
  logic [bdr_pkg::CH_W-1:0]  out_green;
  logic [bdr_pkg::CH_W-1:0]  out_blue;
  logic                      sampled;

  modport source (output valid, out_red, out_green, out_blue, sampled, input ready);
  modport sink (input valid, out_red, out_green, out_blue, sampled, output ready);
endinterface

// File: rtl/bdr_root.sv
// Radius unit: centred offsets, pipelined square root and pipelined division.
module bdr_root (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  bdr_pkg::item_t  in_item,
  input  bdr_pkg::geom_t  geom,
  output logic            out_valid,
  output bdr_pkg::item_t  out_item
);

  localparam int unsigned RW = bdr_pkg::ROOT_W;
  localparam int unsigned QW = bdr_pkg::RAD_W;

  // Front stages: input register, offsets, squares.
  logic           v0, v1, v2;
  bdr_pkg::item_t it0, it1, it2, it1_next, it2_next, it3_next;

  // Square root stages, one result bit each.
  logic [RW:0]                    sv;
  bdr_pkg::item_t                 sit  [RW+1];
  logic [bdr_pkg::REM_W-1:0]      srem [RW+1];
  logic [RW-1:0]                  sroot[RW+1];
  logic [bdr_pkg::SUM_W:0]        sum_ext[RW];
  logic [1:0]                     pair [RW];
  logic [bdr_pkg::REM_W-1:0]      remsh[RW];
  logic [bdr_pkg::REM_W-1:0]      trial[RW];
  logic [bdr_pkg::REM_W-1:0]      srem_next [RW];
  logic [RW-1:0]                  sroot_next[RW];

  // Division stages, one quotient bit each.
  logic [QW:0]                    dv;
  bdr_pkg::item_t                 dit [QW+1];
  logic [RW-1:0]                  drem[QW+1];
  logic [QW-1:0]                  dq  [QW+1];
  logic [QW:0]                    dsat;
  logic [bdr_pkg::DIV_W-1:0]      dsh [QW];
  logic [QW-1:0]                  take;
  logic [RW-1:0]                  drem_next[QW];
  logic [QW-1:0]                  dq_next  [QW];
  logic                           sat;
  logic signed [2*bdr_pkg::OFS_W-1:0] prx, pry;

  always_comb begin
    it1_next = it0;
    it1_next.dx2 = $signed({1'b0, it0.x, 1'b0}) - $signed({1'b0, geom.wm1});
    it1_next.dy2 = $signed({1'b0, it0.y, 1'b0}) - $signed({1'b0, geom.hm1});
    it1_next.in_frame = ({1'b0, it0.x} < geom.w) && ({1'b0, it0.y} < geom.h);

    prx = it1.dx2 * it1.dx2;
    pry = it1.dy2 * it1.dy2;
    it2_next = it1;
    it2_next.sqx = prx[bdr_pkg::SQ_W-1:0];
    it2_next.sqy = pry[bdr_pkg::SQ_W-1:0];

    it3_next = it2;
    it3_next.sum = {1'b0, it2.sqx} + {1'b0, it2.sqy};
  end

  // Digit-by-digit square root of sum * 2^32; the low pairs are all zero.
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      sum_ext[k] = {1'b0, sit[k].sum};
      if (RW - 1 - k >= bdr_pkg::ZERO_PAIRS) begin
        pair[k] = sum_ext[k][2*(RW-1-k-bdr_pkg::ZERO_PAIRS) +: 2];
      end else begin
        pair[k] = 2'b00;
      end
      remsh[k] = {srem[k][bdr_pkg::REM_W-3:0], pair[k]};
      trial[k] = bdr_pkg::REM_W'({sroot[k], 2'b01});
      if (remsh[k] >= trial[k]) begin
        srem_next[k]  = remsh[k] - trial[k];
        sroot_next[k] = {sroot[k][RW-2:0], 1'b1};
      end else begin
        srem_next[k]  = remsh[k];
        sroot_next[k] = {sroot[k][RW-2:0], 1'b0};
      end
    end
  end

  // Restoring division of the root by n2, with saturation decided up front.
  assign sat = {1'b0, sroot[RW]} >= {geom.n2, {QW{1'b0}}};

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      dsh[j]  = bdr_pkg::DIV_W'(geom.n2) << (QW - 1 - j);
      take[j] = !dsat[j] && ({1'b0, drem[j]} >= dsh[j]);
      if (take[j]) begin
        drem_next[j] = drem[j] - dsh[j][RW-1:0];
        dq_next[j]   = dq[j] | (QW'(1) << (QW - 1 - j));
      end else begin
        drem_next[j] = drem[j];
        dq_next[j]   = dq[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      sv <= '0;
      dv <= '0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      sv <= {sv[RW-1:0], v2};
      dv <= {dv[QW-1:0], sv[RW]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= in_item;
      it1 <= it1_next;
      it2 <= it2_next;
      sit[0]   <= it3_next;
      srem[0]  <= '0;
      sroot[0] <= '0;
      for (int k = 0; k < RW; k++) begin
        sit[k+1]   <= sit[k];
        srem[k+1]  <= srem_next[k];
        sroot[k+1] <= sroot_next[k];
      end
      dit[0]  <= sit[RW];
      drem[0] <= sroot[RW];
      dq[0]   <= sat ? bdr_pkg::RAD_MAX : '0;
      dsat[0] <= sat;
      for (int j = 0; j < QW; j++) begin
        dit[j+1]  <= dit[j];
        drem[j+1] <= drem_next[j];
        dq[j+1]   <= dq_next[j];
        dsat[j+1] <= dsat[j];
      end
    end
  end

  always_comb begin
    out_item   = dit[QW];
    out_item.r = dq[QW];
  end
  assign out_valid = dv[QW];

endmodule

// File: rtl/bdr_map.sv
// Mapping unit: radial polynomial by Horner steps and source point with bounds check.
module bdr_map #(
  parameter int unsigned FRAC_BITS = bdr_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  bdr_pkg::item_t  in_item,
  input  bdr_pkg::geom_t  geom,
  output logic            out_valid,
  output bdr_pkg::item_t  out_item
);

  localparam int unsigned NS  = 9;
  localparam int unsigned SXW = bdr_pkg::NX_W + FRAC_BITS;

  logic [NS-1:0]  mv;
  bdr_pkg::item_t mit[NS];
  bdr_pkg::item_t s_item, b_item;

  logic signed [34:0]                   p1;
  logic signed [18:0]                   t1;
  logic signed [37:0]                   p2;
  logic signed [21:0]                   t2;
  logic signed [40:0]                   p3;
  logic signed [bdr_pkg::PROD_W-1:0]    px, py;
  logic signed [bdr_pkg::NX_W-1:0]      nx, ny;
  logic signed [SXW-1:0]                ex, ey, sx_next, sy_next, sx, sy;
  logic [SXW-1:0]                       lx, ly;
  logic                                 okx, oky;

  always_comb begin
    s_item = mit[4];
    s_item.s = bdr_pkg::SCALE_W'(p3 >>> 16) + bdr_pkg::SCALE_W'(geom.d);

    nx = bdr_pkg::NX_W'(px) + $signed({13'b0, geom.wm1, {bdr_pkg::CTR_SHIFT{1'b0}}});
    ny = bdr_pkg::NX_W'(py) + $signed({13'b0, geom.hm1, {bdr_pkg::CTR_SHIFT{1'b0}}});
    ex = SXW'(nx);
    ey = SXW'(ny);
    ex = ex <<< FRAC_BITS;
    ey = ey <<< FRAC_BITS;
    sx_next = ex >>> bdr_pkg::SRC_SHIFT;
    sy_next = ey >>> bdr_pkg::SRC_SHIFT;

    lx  = SXW'({geom.wm1, {FRAC_BITS{1'b0}}});
    ly  = SXW'({geom.hm1, {FRAC_BITS{1'b0}}});
    okx = !sx[SXW-1] && ($unsigned(sx) < lx);
    oky = !sy[SXW-1] && ($unsigned(sy) < ly);
    b_item = mit[7];
    b_item.in_frame = mit[7].in_frame && okx && oky;
    b_item.xb = sx[FRAC_BITS +: bdr_pkg::DIM_W];
    b_item.yb = sy[FRAC_BITS +: bdr_pkg::DIM_W];
    b_item.fx = bdr_pkg::FRAC_MAX'(sx[FRAC_BITS-1:0]);
    b_item.fy = bdr_pkg::FRAC_MAX'(sy[FRAC_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else if (en) begin
      mv <= {mv[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mit[0] <= in_item;
      p1     <= geom.a * $signed({1'b0, in_item.r});
      mit[1] <= mit[0];
      t1     <= 19'(p1 >>> 16) + 19'(geom.b);
      mit[2] <= mit[1];
      p2     <= t1 * $signed({1'b0, mit[1].r});
      mit[3] <= mit[2];
      t2     <= 22'(p2 >>> 16) + 22'(geom.c);
      mit[4] <= mit[3];
      p3     <= t2 * $signed({1'b0, mit[3].r});
      mit[5] <= s_item;
      mit[6] <= mit[5];
      px     <= mit[5].dx2 * mit[5].s;
      py     <= mit[5].dy2 * mit[5].s;
      mit[7] <= mit[6];
      sx     <= sx_next;
      sy     <= sy_next;
      mit[8] <= b_item;
    end
  end

  assign out_valid = mv[NS-1];
  assign out_item  = mit[NS-1];

endmodule

// File: rtl/bdr_frame.sv
// Frame store in four parity banks, running minimum and bilinear blend.
module bdr_frame #(
  parameter int unsigned MAX_WIDTH  = bdr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bdr_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned FRAC_BITS  = bdr_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  bdr_pkg::item_t  in_item,
  output logic            out_valid,
  output bdr_pkg::res_t   out_res
);

  localparam int unsigned HX     = (MAX_WIDTH + 1) / 2;
  localparam int unsigned HY     = (MAX_HEIGHT + 1) / 2;
  localparam int unsigned BXW    = (HX > 1) ? $clog2(HX) : 1;
  localparam int unsigned BYW    = (HY > 1) ? $clog2(HY) : 1;
  localparam int unsigned BDEPTH = 1 << (BXW + BYW);
  localparam int unsigned WW     = FRAC_BITS + 1;
  localparam int unsigned PW     = 2 * FRAC_BITS + 1;
  localparam int unsigned MW     = PW + bdr_pkg::CH_W;
  localparam int unsigned XW     = bdr_pkg::XC_W;
  localparam int unsigned CW     = bdr_pkg::CH_W;

  logic [CW-1:0]          run_min, min3;
  logic                   wr_item;
  logic [XW-1:0]          wx, wy, rx0, ry0, rx1, ry1;
  logic [bdr_pkg::RGB_W-1:0] rdata[4];

  logic [WW-1:0]          one, wx0, wx1, wy0, wy1;
  logic [PW-1:0]          wt[4];
  logic [2*WW-1:0]        wprod[4];

  logic                   v1, v2, v3, k3;
  bdr_pkg::item_t         it1, it2, it1_next;
  logic [bdr_pkg::RGB_W-1:0] pix[4];
  logic [MW-1:0]          prod[4][3];
  logic [CW-1:0]          term[4][3], term_next[4][3];
  logic [CW+1:0]          acc[3];
  bdr_pkg::res_t          res_next;

  // Write side: the item must land inside the store.
  assign wr_item = in_valid && (in_item.kind == bdr_pkg::KIND_WRITE) &&
                   ({4'b0, in_item.x} < XW'(MAX_WIDTH)) &&
                   ({4'b0, in_item.y} < XW'(MAX_HEIGHT));
  assign wx  = XW'(in_item.x);
  assign wy  = XW'(in_item.y);
  assign rx0 = XW'(in_item.xb);
  assign ry0 = XW'(in_item.yb);
  assign rx1 = rx0 + XW'(1);
  assign ry1 = ry0 + XW'(1);

  always_comb begin
    min3 = run_min;
    if (in_item.rgb[0 +: CW] < min3) min3 = in_item.rgb[0 +: CW];
    if (in_item.rgb[CW +: CW] < min3) min3 = in_item.rgb[CW +: CW];
    if (in_item.rgb[2*CW +: CW] < min3) min3 = in_item.rgb[2*CW +: CW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= bdr_pkg::MIN_RST;
    end else if (en && wr_item) begin
      run_min <= min3;
    end
  end

  // Bank index is {y parity, x parity}; the four neighbours hit each bank once.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX_PAR = 1'(b % 2);
    localparam logic BY_PAR = 1'(b / 2);
    logic [bdr_pkg::RGB_W-1:0] mem [BDEPTH];
    logic [XW-1:0]             bx, by;
    logic                      we;
    logic [BXW+BYW-1:0]        waddr, raddr;

    assign bx    = (rx0[0] == BX_PAR) ? rx0 : rx1;
    assign by    = (ry0[0] == BY_PAR) ? ry0 : ry1;
    assign raddr = {by[1 +: BYW], bx[1 +: BXW]};
    assign waddr = {wy[1 +: BYW], wx[1 +: BXW]};
    assign we    = en && wr_item && (wx[0] == BX_PAR) && (wy[0] == BY_PAR);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= in_item.rgb;
      end
      if (en) begin
        rdata[b] <= mem[raddr];
      end
    end
  end

  // Weights are formed alongside the memory read.
  always_comb begin
    one = {1'b1, {FRAC_BITS{1'b0}}};
    wx1 = WW'(in_item.fx[FRAC_BITS-1:0]);
    wy1 = WW'(in_item.fy[FRAC_BITS-1:0]);
    wx0 = one - wx1;
    wy0 = one - wy1;
    wprod[0] = wx0 * wy0;
    wprod[1] = wx1 * wy0;
    wprod[2] = wx0 * wy1;
    wprod[3] = wx1 * wy1;
    it1_next = in_item;
    it1_next.minv = run_min;
  end

  // Neighbour n sits at (xb + n[0], yb + n[1]).
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      pix[n] = rdata[{it1.yb[0] ^ n[1], it1.xb[0] ^ n[0]}];
      for (int ch = 0; ch < 3; ch++) begin
        prod[n][ch]      = MW'(wt[n]) * MW'(pix[n][CW*ch +: CW]);
        term_next[n][ch] = prod[n][ch][2*FRAC_BITS +: CW];
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = (CW+2)'(term[0][ch]) + (CW+2)'(term[1][ch]) +
                (CW+2)'(term[2][ch]) + (CW+2)'(term[3][ch]);
    end
    if (it2.in_frame) begin
      res_next.red     = acc[0][CW-1:0];
      res_next.green   = acc[1][CW-1:0];
      res_next.blue    = acc[2][CW-1:0];
      res_next.sampled = 1'b1;
    end else begin
      res_next.red     = it2.minv;
      res_next.green   = it2.minv;
      res_next.blue    = it2.minv;
      res_next.sampled = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1 <= it1_next;
      for (int n = 0; n < 4; n++) begin
        wt[n] <= wprod[n][PW-1:0];
      end
      it2  <= it1;
      term <= term_next;
      k3      <= it2.kind;
      out_res <= res_next;
    end
  end

  assign out_valid = v3 && (k3 == bdr_pkg::KIND_READ);

endmodule

// File: rtl/barrel_distortion_remap_bilinear.sv
// Top level of the barrel distortion remapper with bilinear resampling.
// The block takes one item per clock while it is not stalled and gives one
// result per read item; write items give no result. The pipeline is built
// from the bit-per-stage square root (27 stages) and divider that form the
// radius, the six Horner stages of the scale polynomial and the banked
// frame store. The whole pipeline advances together: it stalls only while
// a result sits in the output register and the sink does not take it. The
// frame store is split into four banks by the parity of x and y, so the four
// neighbours of a source point are fetched in the same cycle, and writes
// commit at the same stage as reads, so a read always sees every earlier
// write. The store has no reset and needs no clearing pass; a read of a
// location never written returns whatever it holds. The user must write the
// registers only while no item is in flight; the block does not enforce it.
module barrel_distortion_remap_bilinear #(
  parameter int unsigned MAX_WIDTH  = bdr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bdr_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned FRAC_BITS  = bdr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  bdr_in_if.sink                          in,
  bdr_out_if.source                       out,
  input  logic                            cfg_we,
  input  logic [bdr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned DW = bdr_pkg::DIM_W;
  localparam int unsigned WC = bdr_pkg::XC_W;

  // Register file.
  logic [DW-1:0]                  image_width, image_height;
  logic signed [bdr_pkg::COEF_W-1:0] coef_quartic, coef_cubic, coef_square;

  bdr_pkg::geom_t geom;
  logic [DW-1:0]  w_cl, h_cl;

  // Pipeline links.
  logic           en;
  bdr_pkg::item_t in_item, root_item, map_item;
  logic           root_valid, map_valid, res_valid;
  bdr_pkg::res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bdr_pkg::WIDTH_RST;
      image_height <= bdr_pkg::HEIGHT_RST;
      coef_quartic <= bdr_pkg::QUARTIC_RST;
      coef_cubic   <= bdr_pkg::CUBIC_RST;
      coef_square  <= bdr_pkg::SQUARE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[DW-1:0];
        bdr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[DW-1:0];
        bdr_pkg::REG_COEF_QUARTIC: coef_quartic <= $signed(cfg_data);
        bdr_pkg::REG_COEF_CUBIC:   coef_cubic   <= $signed(cfg_data);
        bdr_pkg::REG_COEF_SQUARE:  coef_square  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // The frame in use is held to at least two pixels and at most the store.
  always_comb begin
    if (image_width < DW'(2)) begin
      w_cl = DW'(2);
    end else if (WC'(image_width) > WC'(MAX_WIDTH)) begin
      w_cl = DW'(MAX_WIDTH);
    end else begin
      w_cl = image_width;
    end
    if (image_height < DW'(2)) begin
      h_cl = DW'(2);
    end else if (WC'(image_height) > WC'(MAX_HEIGHT)) begin
      h_cl = DW'(MAX_HEIGHT);
    end else begin
      h_cl = image_height;
    end
    geom.w   = w_cl;
    geom.h   = h_cl;
    geom.wm1 = w_cl - DW'(1);
    geom.hm1 = h_cl - DW'(1);
    geom.n2  = (w_cl < h_cl) ? geom.wm1 : geom.hm1;
    geom.a   = coef_quartic;
    geom.b   = coef_cubic;
    geom.c   = coef_square;
    // The constant term makes the scale exactly one at the unit radius.
    geom.d   = bdr_pkg::Q14_ONE - bdr_pkg::D_W'(coef_quartic)
               - bdr_pkg::D_W'(coef_cubic) - bdr_pkg::D_W'(coef_square);
  end

  // One enable moves every stage; it drops only when a result is held.
  assign en       = !out.valid || out.ready;
  assign in.ready = en;

  always_comb begin
    in_item      = '0;
    in_item.kind = in.kind;
    in_item.x    = in.pos_x;
    in_item.y    = in.pos_y;
    in_item.rgb  = {in.in_blue, in.in_green, in.in_red};
  end

  bdr_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in.valid),
    .in_item   (in_item),
    .geom      (geom),
    .out_valid (root_valid),
    .out_item  (root_item)
  );

  bdr_map #(
    .FRAC_BITS (FRAC_BITS)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .in_item   (root_item),
    .geom      (geom),
    .out_valid (map_valid),
    .out_item  (map_item)
  );

  bdr_frame #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (map_valid),
    .in_item   (map_item),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign out.valid     = res_valid;
  assign out.out_red   = res.red;
  assign out.out_green = res.green;
  assign out.out_blue  = res.blue;
  assign out.sampled   = res.sampled;

endmodule
